// ===== src/cosine_similarity_engine_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COSINE_SIMILARITY_ENGINE_DEFINES_SVH
`define COSINE_SIMILARITY_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine similarity check failed");

// Next-cycle implication, disabled while reset is low
`define CSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine similarity check failed");

`endif

// ===== src/cse_pkg.sv =====
package cse_pkg;

    localparam int ELEM_BITS = 16;
    localparam int DOT_W     = 42;
    localparam int NORM_W    = 41;
    localparam int HALF_W    = 21;
    localparam int PROD_W    = 84;
    localparam int SRCH_W    = 120;
    localparam int SIM_W     = 16;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL,
        ST_INIT,
        ST_SA,
        ST_SB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       acc_en;
        logic       mul_en;
        logic [2:0] mul_idx;
        logic       srch_init;
        logic       srch_a;
        logic       srch_b;
        logic [3:0] bit_idx;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic pend_last;
        logic final_done;
        logic out_free;
    } t_sts;

endpackage

// ===== src/cse_ctrl.sv =====
module cse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    input  cse_pkg::t_sts i_sts,
    output cse_pkg::t_cmd o_cmd
);
    import cse_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        // a closing pair waits for the divide unit to be free
        o_s_tready = !i_s_tlast || ((r_state == ST_ACC) && !i_sts.pend_last);
        o_cmd.acc_en  = i_s_tvalid && o_s_tready;
        o_cmd.mul_idx = r_cnt[2:0];
        o_cmd.bit_idx = r_cnt;
        case (r_state)
            ST_ACC: begin
                if (i_sts.final_done) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt[2:0] == 3'd7) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_cnt   = 4'd15;
                n_state = ST_SA;
            end
            ST_SA: begin
                o_cmd.srch_a = 1'b1;
                n_state = ST_SB;
            end
            ST_SB: begin
                o_cmd.srch_b = 1'b1;
                if (r_cnt == 4'd0) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt   = r_cnt - 4'd1;
                    n_state = ST_SA;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

endmodule

// ===== src/cse_dp.sv =====
module cse_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_s_tdata,
    input  logic          i_s_tlast,
    input  logic          i_m_tready,
    input  cse_pkg::t_cmd i_cmd,
    output cse_pkg::t_sts o_sts,
    output logic          o_m_tvalid,
    output logic [15:0]   o_m_tdata,
    output logic          o_m_tuser
);
    import cse_pkg::*;

    localparam logic signed [DOT_W:0] DotMax = (43'sd1 <<< (DOT_W - 1)) - 43'sd1;
    localparam logic signed [DOT_W:0] DotMin = -(43'sd1 <<< (DOT_W - 1));

    logic signed [ELEM_BITS-1:0] elem_a, elem_b;
    logic signed [31:0] r_pab, r_paa, r_pbb;
    logic               r_pv, r_plast;
    logic signed [DOT_W-1:0] r_dot, r_fdot;
    logic [NORM_W-1:0]       r_na, r_nb, r_fna, r_fnb;
    logic signed [DOT_W:0]   dsum;
    logic signed [DOT_W-1:0] dsat;
    logic [NORM_W:0]         nasum, nbsum;
    logic [NORM_W-1:0]       nasat, nbsat;

    logic [DOT_W-1:0]  mag, mx, my;
    logic [HALF_W-1:0] xh, yh;
    logic [2*HALF_W-1:0] part;
    logic [PROD_W-1:0] part_sh;
    logic [6:0]        sh;
    logic [PROD_W-1:0] r_p, r_d;

    logic signed [SRCH_W-1:0] r_s, r_tsh, r_psh, r_r, r_cand;
    logic signed [SRCH_W-1:0] cand2, tsh_add;
    logic [SIM_W-1:0]         r_m;
    logic                     ok;

    logic               r_ovalid, r_otuser;
    logic [SIM_W-1:0]   r_otdata, sim;
    logic               degen;

    assign elem_a = i_s_tdata[15:0];
    assign elem_b = i_s_tdata[31:16];

    // square and cross products of the accepted pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.acc_en;
        end
        if (i_cmd.acc_en) begin
            r_pab   <= elem_a * elem_b;
            r_paa   <= elem_a * elem_a;
            r_pbb   <= elem_b * elem_b;
            r_plast <= i_s_tlast;
        end
    end

    // saturating running sums
    always_comb begin
        dsum  = {r_dot[DOT_W-1], r_dot} + 43'(r_pab);
        nasum = {1'b0, r_na} + 42'($unsigned(r_paa));
        nbsum = {1'b0, r_nb} + 42'($unsigned(r_pbb));
        if (dsum > DotMax) begin
            dsat = DotMax[DOT_W-1:0];
        end else if (dsum < DotMin) begin
            dsat = DotMin[DOT_W-1:0];
        end else begin
            dsat = dsum[DOT_W-1:0];
        end
        nasat = nasum[NORM_W] ? '1 : nasum[NORM_W-1:0];
        nbsat = nbsum[NORM_W] ? '1 : nbsum[NORM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (r_pv) begin
            if (r_plast) begin
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
            end else begin
                r_dot <= dsat;
                r_na  <= nasat;
                r_nb  <= nbsat;
            end
        end
    end

    // capture the closing sums for the divide unit
    always_ff @(posedge i_clk) begin
        if (r_pv && r_plast) begin
            r_fdot <= dsat;
            r_fna  <= nasat;
            r_fnb  <= nbsat;
        end
    end

    assign o_sts.pend_last  = r_pv && r_plast;
    assign o_sts.final_done = r_pv && r_plast;
    assign o_sts.out_free   = !r_ovalid || i_m_tready;

    // norm product and dot square, one 21x21 partial product a cycle
    always_comb begin
        mag = r_fdot[DOT_W-1] ? DOT_W'(-r_fdot) : DOT_W'(r_fdot);
        mx  = i_cmd.mul_idx[2] ? mag : {1'b0, r_fna};
        my  = i_cmd.mul_idx[2] ? mag : {1'b0, r_fnb};
        xh  = i_cmd.mul_idx[0] ? mx[DOT_W-1:HALF_W] : mx[HALF_W-1:0];
        yh  = i_cmd.mul_idx[1] ? my[DOT_W-1:HALF_W] : my[HALF_W-1:0];
        part = xh * yh;
        sh   = 7'(HALF_W) * (7'(i_cmd.mul_idx[0]) + 7'(i_cmd.mul_idx[1]));
        part_sh = PROD_W'(part) << sh;
    end

    always_ff @(posedge i_clk) begin
        if (r_pv && r_plast) begin
            r_p <= '0;
            r_d <= '0;
        end else if (i_cmd.mul_en) begin
            if (i_cmd.mul_idx[2]) begin
                r_d <= r_d + part_sh;
            end else begin
                r_p <= r_p + part_sh;
            end
        end
    end

    // bit-serial search for the rounded ratio, k = 2m - 1 kept incrementally
    always_comb begin
        cand2   = r_cand + r_psh;
        ok      = (cand2 <= r_r) && !r_m[SIM_W-1];
        tsh_add = ok ? r_tsh + (r_psh <<< 1) : r_tsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_s   <= SRCH_W'(r_p);
            r_tsh <= -(SRCH_W'(r_p) <<< 17);
            r_psh <= SRCH_W'(r_p) <<< 32;
            r_r   <= SRCH_W'(r_d) <<< 32;
            r_m   <= '0;
        end else if (i_cmd.srch_a) begin
            r_cand <= r_s + r_tsh;
        end else if (i_cmd.srch_b) begin
            if (ok) begin
                r_s <= cand2;
                r_m[i_cmd.bit_idx] <= 1'b1;
            end
            r_tsh <= tsh_add >>> 1;
            r_psh <= r_psh >>> 2;
        end
    end

    // sign, clamp and zero-norm handling
    always_comb begin
        degen = (r_fna == '0) || (r_fnb == '0);
        if (degen) begin
            sim = '0;
        end else if (r_fdot[DOT_W-1]) begin
            sim = -r_m;
        end else if (r_m[SIM_W-1]) begin
            sim = 16'h7fff;
        end else begin
            sim = r_m;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_otdata <= sim;
            r_otuser <= degen;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_otdata;
    assign o_m_tuser  = r_otuser;

endmodule

// ===== src/cosine_similarity_engine.sv =====
// Element pairs are taken one per cycle; a pair without tlast never stalls.
// After the closing pair the result is built by, in order: 1 product stage,
// 8 partial products on one 21x21 multiplier, 1 setup, 32 search steps, 1 load.
// A new closing pair is accepted only once the previous result is loaded.
// Synchronous active-low reset clears the sums, the controller and the output valid.
module cosine_similarity_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] elem_a, [31:16] elem_b
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] similarity
    output logic        o_m_tuser    // [0] degenerate
);
    import cse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cse_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== src/cse_checker.sv =====
`include "cosine_similarity_engine_defines.svh"

module cse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // stalled result holds
    `CSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // zero norm forces zero similarity
    `CSE_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == 16'h0000)

    // two closing pairs never transfer back to back
    `CSE_ASSERT_NXT(a_last_gap, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !(i_s_tvalid && o_s_tready && i_s_tlast))

endmodule

bind cosine_similarity_engine cse_checker u_cse_checker (.*);
